[hw/rtl/bkee_pkg.sv]
// Package with beat types, pipeline stage types and constants for the kernel entry pipeline.
package bkee_pkg;

    localparam int WS_W   = 32;
    localparam int RN_W   = 65;
    localparam int RR_W   = 66;
    localparam int AB_W   = 66;
    localparam int X_W    = 97;
    localparam int Y_W    = 163;
    localparam int NUM_W  = 179;
    localparam int DEN_W  = 132;
    localparam int Q_W    = 64;
    localparam int DIV_N  = 64;
    localparam int PRE_N  = 6;
    localparam int VLD_N  = PRE_N + DIV_N + 1;

    localparam logic [31:0] SCALE_STOKES  = 32'd1367130551;
    localparam logic [31:0] SCALE_LAPLACE = 32'd683565276;
    localparam logic [63:0] HALF_Q40      = 64'h0000_0080_0000_0000;
    localparam logic [64:0] CAP_POS       = 65'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [64:0] CAP_NEG       = 65'h0_8000_0000_0000_0000;

    typedef struct packed {
        logic               same_node;
        logic               row_component;
        logic               col_component;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_normal_x;
        logic signed [31:0] source_normal_y;
        logic signed [31:0] node_weight;
        logic signed [31:0] node_curvature;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] kernel_value;
        logic               saturated;
    } t_out_beat;

    typedef struct packed {
        logic same;
        logic stokes;
        logic eq;
        logic neg;
        logic rrzero;
        logic ovf;
    } t_meta;

    typedef struct packed {
        logic [31:0] kmag;
        logic        kneg;
        logic [31:0] wmag;
        logic        wneg;
        logic [32:0] rm0;
        logic [32:0] rm1;
        logic        rneg0;
        logic        rneg1;
        logic [31:0] nm0;
        logic [31:0] nm1;
        logic        nneg0;
        logic        nneg1;
        logic [32:0] am;
        logic [32:0] bm;
        logic        an;
        logic        bn;
        logic        same;
        logic        stokes;
        logic        eq;
    } t_s1;

    typedef struct packed {
        logic [31:0]     kmag;
        logic            kneg;
        logic [63:0]     wsprod;
        logic            wneg;
        logic [64:0]     p0;
        logic [64:0]     p1;
        logic            sg0;
        logic            sg1;
        logic [65:0]     sq0;
        logic [65:0]     sq1;
        logic [AB_W-1:0] ab;
        logic            an;
        logic            bn;
        logic            same;
        logic            stokes;
        logic            eq;
    } t_s2;

    typedef struct packed {
        logic [31:0]     kmag;
        logic [WS_W-1:0] ws;
        logic [RN_W-1:0] rn;
        logic [RR_W-1:0] rr;
        logic [AB_W-1:0] ab;
        t_meta           meta;
    } t_s3;

    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [RR_W-1:0]  rr;
        logic [DEN_W-1:0] rr2;
        logic [AB_W-1:0]  ab;
        t_meta            meta;
    } t_s4;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_meta            meta;
    } t_s5;

    typedef struct packed {
        t_meta            meta;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   q;
    } t_dst;

    function automatic t_dst div_step(input t_dst s);
        t_dst         o;
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        o    = s;
        rem2 = {s.rem, s.low[Q_W-1]};
        diff = rem2 - {1'b0, s.den};
        o.low = {s.low[Q_W-2:0], 1'b0};
        if (rem2 >= {1'b0, s.den}) begin
            o.rem = diff[DEN_W-1:0];
            o.q   = {s.q[Q_W-2:0], 1'b1};
        end else begin
            o.rem = rem2[DEN_W-1:0];
            o.q   = {s.q[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

[hw/rtl/boundary_kernel_entry_eval_core.sv]
// Top level of the double-layer kernel entry pipeline: operand prep, products and divider.
// Throughput is one beat per cycle when the output beat is not stalled;
// six prep and product stages feed a 64-stage divider.
// The whole pipeline advances together and holds while the output beat is stalled.
// Reset clears all valid bits and selects the Laplace kernel.
module boundary_kernel_entry_eval_core
    import bkee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    logic             r_kernel_select;
    logic [VLD_N-1:0] r_vld;
    t_s1              r_s1, n_s1;
    t_s2              r_s2, n_s2;
    t_s3              r_s3, n_s3;
    t_s4              r_s4, n_s4;
    t_s5              r_s5, n_s5;
    t_dst             r_d [0:DIV_N];
    t_dst             n_d0;
    t_out_beat        r_out, n_out;
    logic             adv;

    assign o_stall = r_vld[VLD_N-1] & i_stall;
    assign adv     = ~o_stall;
    assign o_valid = r_vld[VLD_N-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_select <= 1'b0;
            r_vld           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_kernel_select <= i_cfg_wdata;
            end
            if (adv) begin
                r_vld <= {r_vld[VLD_N-2:0], i_valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_s3   <= n_s3;
            r_s4   <= n_s4;
            r_s5   <= n_s5;
            r_d[0] <= n_d0;
            for (int i = 1; i <= DIV_N; i++) begin
                r_d[i] <= div_step(r_d[i-1]);
            end
            r_out  <= n_out;
        end
    end

    // Differences, magnitudes and operand selection.
    always_comb begin
        logic signed [32:0] d0, d1;
        logic               t0neg, t1neg;
        d0 = {i_data.target_x[31], i_data.target_x} - {i_data.source_x[31], i_data.source_x};
        d1 = {i_data.target_y[31], i_data.target_y} - {i_data.source_y[31], i_data.source_y};
        n_s1.rneg0 = d0[32];
        n_s1.rneg1 = d1[32];
        n_s1.rm0   = d0[32] ? 33'(-d0) : 33'(d0);
        n_s1.rm1   = d1[32] ? 33'(-d1) : 33'(d1);
        n_s1.nneg0 = i_data.source_normal_x[31];
        n_s1.nneg1 = i_data.source_normal_y[31];
        n_s1.nm0   = n_s1.nneg0 ? 32'(-i_data.source_normal_x) : 32'(i_data.source_normal_x);
        n_s1.nm1   = n_s1.nneg1 ? 32'(-i_data.source_normal_y) : 32'(i_data.source_normal_y);
        n_s1.kneg  = i_data.node_curvature[31];
        n_s1.kmag  = n_s1.kneg ? 32'(-i_data.node_curvature) : 32'(i_data.node_curvature);
        n_s1.wneg  = i_data.node_weight[31];
        n_s1.wmag  = n_s1.wneg ? 32'(-i_data.node_weight) : 32'(i_data.node_weight);
        t0neg = ~n_s1.nneg1 && (i_data.source_normal_y != 32'sd0);
        t1neg = n_s1.nneg0;
        if (i_data.same_node) begin
            n_s1.am = {1'b0, i_data.row_component ? n_s1.nm0 : n_s1.nm1};
            n_s1.bm = {1'b0, i_data.col_component ? n_s1.nm0 : n_s1.nm1};
            n_s1.an = i_data.row_component ? t1neg : t0neg;
            n_s1.bn = i_data.col_component ? t1neg : t0neg;
        end else begin
            n_s1.am = i_data.row_component ? n_s1.rm1 : n_s1.rm0;
            n_s1.bm = i_data.col_component ? n_s1.rm1 : n_s1.rm0;
            n_s1.an = i_data.row_component ? n_s1.rneg1 : n_s1.rneg0;
            n_s1.bn = i_data.col_component ? n_s1.rneg1 : n_s1.rneg0;
        end
        n_s1.same   = i_data.same_node;
        n_s1.stokes = r_kernel_select;
        n_s1.eq     = i_data.row_component == i_data.col_component;
    end

    // First products.
    always_comb begin
        n_s2.kmag   = r_s1.kmag;
        n_s2.kneg   = r_s1.kneg;
        n_s2.wneg   = r_s1.wneg;
        n_s2.wsprod = 64'(r_s1.wmag) * 64'(r_s1.stokes ? SCALE_STOKES : SCALE_LAPLACE);
        n_s2.p0     = 65'(r_s1.rm0) * 65'(r_s1.nm0);
        n_s2.p1     = 65'(r_s1.rm1) * 65'(r_s1.nm1);
        n_s2.sg0    = r_s1.rneg0 ^ r_s1.nneg0;
        n_s2.sg1    = r_s1.rneg1 ^ r_s1.nneg1;
        n_s2.sq0    = 66'(r_s1.rm0) * 66'(r_s1.rm0);
        n_s2.sq1    = 66'(r_s1.rm1) * 66'(r_s1.rm1);
        n_s2.ab     = 66'(r_s1.am) * 66'(r_s1.bm);
        n_s2.an     = r_s1.an;
        n_s2.bn     = r_s1.bn;
        n_s2.same   = r_s1.same;
        n_s2.stokes = r_s1.stokes;
        n_s2.eq     = r_s1.eq;
    end

    // Rounded weight scale, signed dot product and squared distance.
    always_comb begin
        logic [63:0] wsr;
        logic        rnneg, wsneg;
        wsr = r_s2.wsprod + 64'h0000_0000_8000_0000;
        n_s3.ws = wsr[63:32];
        if (r_s2.sg0 == r_s2.sg1) begin
            n_s3.rn = r_s2.p0 + r_s2.p1;
            rnneg   = r_s2.sg0;
        end else if (r_s2.p0 >= r_s2.p1) begin
            n_s3.rn = r_s2.p0 - r_s2.p1;
            rnneg   = r_s2.sg0;
        end else begin
            n_s3.rn = r_s2.p1 - r_s2.p0;
            rnneg   = r_s2.sg1;
        end
        wsneg = r_s2.wneg && (n_s3.ws != '0);
        n_s3.rr   = r_s2.sq0 + r_s2.sq1;
        n_s3.kmag = r_s2.kmag;
        n_s3.ab   = r_s2.ab;
        n_s3.meta.same   = r_s2.same;
        n_s3.meta.stokes = r_s2.stokes;
        n_s3.meta.eq     = r_s2.eq;
        n_s3.meta.neg    = wsneg ^ (r_s2.same ? r_s2.kneg : rnneg)
                         ^ (r_s2.stokes & (r_s2.an ^ r_s2.bn)) ^ ~(r_s2.same ^ r_s2.stokes);
        n_s3.meta.rrzero = n_s3.rr == '0;
        n_s3.meta.ovf    = 1'b0;
    end

    // Weight times dot product or curvature, and squared distance squared.
    always_comb begin
        logic [64:0] opb;
        logic [63:0] pl;
        logic [64:0] ph;
        logic [65:0] qa, qb, qc;
        opb = r_s3.meta.same ? 65'(r_s3.kmag) : r_s3.rn;
        pl  = 64'(r_s3.ws) * 64'(opb[31:0]);
        ph  = 65'(r_s3.ws) * 65'(opb[64:32]);
        n_s4.x = X_W'(pl) + {ph, 32'b0};
        qa = 66'(r_s3.rr[32:0]) * 66'(r_s3.rr[32:0]);
        qb = 66'(r_s3.rr[32:0]) * 66'(r_s3.rr[65:33]);
        qc = 66'(r_s3.rr[65:33]) * 66'(r_s3.rr[65:33]);
        n_s4.rr2  = DEN_W'(qa) + DEN_W'({qb, 34'b0}) + {qc, 66'b0};
        n_s4.rr   = r_s3.rr;
        n_s4.ab   = r_s3.ab;
        n_s4.meta = r_s3.meta;
    end

    // Component product for Stokes, then numerator and denominator selection.
    always_comb begin
        logic [65:0]    m00, m01, m10, m11, m20, m21;
        logic [Y_W-1:0] y;
        m00 = 66'(r_s4.x[32:0])  * 66'(r_s4.ab[32:0]);
        m01 = 66'(r_s4.x[32:0])  * 66'(r_s4.ab[65:33]);
        m10 = 66'(r_s4.x[65:33]) * 66'(r_s4.ab[32:0]);
        m11 = 66'(r_s4.x[65:33]) * 66'(r_s4.ab[65:33]);
        m20 = 66'(r_s4.x[96:66]) * 66'(r_s4.ab[32:0]);
        m21 = 66'(r_s4.x[96:66]) * 66'(r_s4.ab[65:33]);
        y = Y_W'(m00) + (Y_W'(m01) << 33) + (Y_W'(m10) << 33) + (Y_W'(m11) << 66)
          + (Y_W'(m20) << 66) + (Y_W'(m21) << 99);
        if (!r_s4.meta.stokes) begin
            y = Y_W'(r_s4.x);
        end
        if (r_s4.meta.same) begin
            n_s5.num = NUM_W'(y);
            n_s5.den = r_s4.meta.stokes ? (DEN_W'(1) << 65) : (DEN_W'(1) << 9);
        end else begin
            n_s5.num = {y, 16'b0};
            n_s5.den = r_s4.meta.stokes ? r_s4.rr2 : DEN_W'(r_s4.rr);
        end
        n_s5.meta = r_s4.meta;
    end

    // Divider entry: a high part at or above the divisor means the quotient overflows.
    always_comb begin
        logic [NUM_W-Q_W-1:0] hi;
        hi = r_s5.num[NUM_W-1:Q_W];
        n_d0.meta     = r_s5.meta;
        n_d0.meta.ovf = DEN_W'(hi) >= r_s5.den;
        n_d0.rem      = DEN_W'(hi);
        n_d0.den      = r_s5.den;
        n_d0.low      = r_s5.num[Q_W-1:0];
        n_d0.q        = '0;
    end

    // Rounding, sign, offset and saturation.
    always_comb begin
        t_dst        f;
        logic [64:0] qr;
        logic [64:0] cap;
        logic [63:0] off, m;
        logic        negf, big;
        f  = r_d[DIV_N];
        qr = ({f.rem, 1'b0} >= {1'b0, f.den}) ? 65'(f.q) + 65'd1 : 65'(f.q);
        negf = f.meta.neg && ((qr != '0) || f.meta.ovf);
        cap  = negf ? CAP_NEG : CAP_POS;
        big  = f.meta.ovf || (qr > cap);
        m    = big ? cap[63:0] : qr[63:0];
        off  = f.meta.stokes ? (f.meta.eq ? -HALF_Q40 : 64'd0) : HALF_Q40;
        if (f.meta.same) begin
            n_out.kernel_value = off + (f.meta.neg ? -qr[63:0] : qr[63:0]);
            n_out.saturated    = 1'b0;
        end else if (f.meta.rrzero) begin
            n_out.kernel_value = '0;
            n_out.saturated    = 1'b1;
        end else begin
            n_out.kernel_value = negf ? -m : m;
            n_out.saturated    = big;
        end
    end

endmodule

[verif/tb_boundary_kernel_entry_eval_core.sv]
// Self-checking testbench for the double-layer kernel entry pipeline, Laplace and Stokes.
module tb_boundary_kernel_entry_eval_core
    import bkee_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_beat o_data;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    localparam logic KERNEL_LAPLACE = 1'b0;
    localparam logic KERNEL_STOKES  = 1'b1;

    t_out_beat entry_queue[$];
    bit        kernel_sel = KERNEL_LAPLACE;
    int        err_count = 0;
    bit        idle_en = 1'b1;
    int        rx_hold = 0;

    boundary_kernel_entry_eval_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] mag64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_out_beat predict_entry(t_in_beat b, bit stokes);
        t_out_beat   res;
        longint      r0, r1, n0, n1, t0, t1;
        logic [63:0] wmag, kmag, wsmag, scale, rm0, rm1, nm0, nm1, am, bm, p0, p1, rnmag, tm;
        bit          wneg, kneg, wsneg, rn0, rn1, nn0, nn1, an, bn, s0, s1, rnneg, neg, sat;
        logic [255:0] num, den, q, rem, cap, rr;
        wneg  = b.node_weight < 0;
        kneg  = b.node_curvature < 0;
        wmag  = mag64(longint'(b.node_weight));
        kmag  = mag64(longint'(b.node_curvature));
        scale = stokes ? 64'(SCALE_STOKES) : 64'(SCALE_LAPLACE);
        wsmag = (wmag * scale + 64'h8000_0000) >> 32;
        wsneg = wneg && (wsmag != 0);
        n0 = longint'(b.source_normal_x);
        n1 = longint'(b.source_normal_y);
        res = '0;
        if (b.same_node) begin
            if (!stokes) begin
                q   = 256'(kmag) * 256'(wsmag);
                q   = (q + 256'd256) >> 9;
                tm  = q[63:0];
                res.kernel_value = HALF_Q40 + ((kneg ^ wsneg) ? -tm : tm);
            end else begin
                t0 = -n1;
                t1 = n0;
                an = (b.row_component ? t1 : t0) < 0;
                bn = (b.col_component ? t1 : t0) < 0;
                am = mag64(b.row_component ? t1 : t0);
                bm = mag64(b.col_component ? t1 : t0);
                q  = 256'(kmag) * 256'(wsmag) * 256'(am * bm);
                q  = (q + (256'd1 << 64)) >> 65;
                tm = q[63:0];
                res.kernel_value = (b.row_component == b.col_component) ? -HALF_Q40 : 64'd0;
                res.kernel_value = res.kernel_value
                                 + (!(kneg ^ wsneg ^ an ^ bn) ? -tm : tm);
            end
            return res;
        end
        r0 = longint'(b.target_x) - longint'(b.source_x);
        r1 = longint'(b.target_y) - longint'(b.source_y);
        rn0 = r0 < 0;  rn1 = r1 < 0;  nn0 = n0 < 0;  nn1 = n1 < 0;
        rm0 = mag64(r0);  rm1 = mag64(r1);  nm0 = mag64(n0);  nm1 = mag64(n1);
        p0 = rm0 * nm0;
        p1 = rm1 * nm1;
        s0 = rn0 ^ nn0;
        s1 = rn1 ^ nn1;
        if (s0 == s1) begin
            rnneg = s0; rnmag = p0 + p1;
        end else if (p0 >= p1) begin
            rnneg = s0; rnmag = p0 - p1;
        end else begin
            rnneg = s1; rnmag = p1 - p0;
        end
        rr = 256'(rm0 * rm0) + 256'(rm1 * rm1);
        if (rr == 0) begin
            res.saturated = 1'b1;
            return res;
        end
        num = (256'(wsmag) * 256'(rnmag)) << 16;
        if (!stokes) begin
            den = rr;
            neg = !(wsneg ^ rnneg);
        end else begin
            am  = b.row_component ? rm1 : rm0;
            bm  = b.col_component ? rm1 : rm0;
            an  = b.row_component ? rn1 : rn0;
            bn  = b.col_component ? rn1 : rn0;
            num = num * 256'(am * bm);
            den = rr * rr;
            neg = wsneg ^ rnneg ^ an ^ bn;
        end
        q   = num / den;
        rem = num % den;
        if ((rem << 1) >= den) q = q + 256'd1;
        if (q == 0) neg = 1'b0;
        cap = neg ? (256'd1 << 63) : ((256'd1 << 63) - 256'd1);
        sat = 1'b0;
        if (q > cap) begin
            q = cap;
            sat = 1'b1;
        end
        res.kernel_value = neg ? -q[63:0] : q[63:0];
        res.saturated    = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_valid && !i_stall) begin
            if (entry_queue.size() == 0) begin
                report_mismatch("unexpected beat", o_data.kernel_value, '0);
            end else begin
                exp_beat = entry_queue.pop_front();
                if (o_data.kernel_value !== exp_beat.kernel_value)
                    report_mismatch("kernel_value", o_data.kernel_value, exp_beat.kernel_value);
                if (o_data.saturated !== exp_beat.saturated)
                    report_mismatch("saturated", 64'(o_data.saturated), 64'(exp_beat.saturated));
            end
        end
    end

    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_stall <= 1'b1;
                rx_hold--;
            end else if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 9);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(t_in_beat b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (o_stall);
        entry_queue = {entry_queue, predict_entry(b, kernel_sel)};
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (entry_queue.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_kernel(logic sel);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        kernel_sel = sel;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom) >>> $urandom_range(2, 6));
            2: return 32'($signed($urandom) >>> $urandom_range(6, 20));
            default: return 32'($signed($urandom) >>> $urandom_range(20, 31));
        endcase
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.same_node       = ($urandom_range(0, 7) == 0);
        b.row_component   = 1'($urandom);
        b.col_component   = 1'($urandom);
        b.target_x        = rand_word();
        b.target_y        = rand_word();
        b.source_x        = rand_word();
        b.source_y        = rand_word();
        b.source_normal_x = rand_word();
        b.source_normal_y = rand_word();
        b.node_weight     = rand_word();
        b.node_curvature  = rand_word();
        if ($urandom_range(0, 15) == 0) begin
            b.source_x = b.target_x;
            b.source_y = b.target_y;
        end
        return b;
    endfunction

    task automatic test_directed();
        t_in_beat b;
        logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1000_0000};
        for (int i = 0; i < 4; i++) begin
            b = '{1'b0, 1'b0, 1'b1, ext[i], ext[i], ext[3 - i], ext[3 - i],
                  ext[i], ext[3 - i], ext[i], ext[3 - i]};
            send_beat(b);
        end
        b = '{1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
        send_beat(b);
        b.node_weight = 32'h8000_0000;
        send_beat(b);
        b = '{1'b0, 1'b0, 1'b0, 32'h0123_4567, 32'h0765_4321, 32'h0123_4567, 32'h0765_4321,
              32'h1000_0000, 32'h0, 32'h0100_0000, 32'h0100_0000};
        send_beat(b);
        for (int i = 0; i < 4; i++) begin
            b = '{1'b1, i[1], i[0], 32'h0, 32'h0, 32'h0, 32'h0,
                  ext[i], ext[3 - i], ext[i], ext[(i + 1) % 4]};
            send_beat(b);
        end
        b = '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_beat(b);
    endtask

    task automatic test_random(int count);
        repeat (count) send_beat(rand_beat());
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        repeat (150) send_beat(rand_beat());
    endtask

    task automatic test_sender_pause();
        repeat (40) send_beat(rand_beat());
        i_valid <= 1'b0;
        while (entry_queue.size() != 0) @(posedge i_clk);
        repeat (40) send_beat(rand_beat());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_kernel(KERNEL_LAPLACE);
        test_directed();
        test_random(400);
        write_kernel(KERNEL_STOKES);
        test_directed();
        test_random(400);
        test_backpressure();
        write_kernel(KERNEL_LAPLACE);
        test_sender_pause();
        test_random(300);
        write_kernel(KERNEL_STOKES);
        test_random(300);
        idle_en = 1'b0;
        test_random(200);
        wait_drain();
        if (err_count == 0) begin
            $display("** boundary_kernel_entry_eval_core: PASSED **");
        end else begin
            $display("** boundary_kernel_entry_eval_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** boundary_kernel_entry_eval_core: FAILED **");
        $finish;
    end

endmodule

[boundary_kernel_entry_eval_core.f]
hw/rtl/bkee_pkg.sv
hw/rtl/boundary_kernel_entry_eval_core.sv
verif/tb_boundary_kernel_entry_eval_core.sv
